// ----- src/secded_pkg.sv -----
// ----------------------------------------------------------------------------
// SECDED codec package
// Transaction types, code position table and status codes shared by the
// encoder, the corrector and the top level of the SECDED word codec.
// ----------------------------------------------------------------------------
`default_nettype none

package secded_pkg;

	// Request codes.
	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_CLEAN     = 2'd0;
	localparam logic [1:0] ST_CORRECTED = 2'd1;
	localparam logic [1:0] ST_UNCORR    = 2'd2;

	// Geometry of the code.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned CHECK_W = 7;

	// Highest code position that carries a data bit.
	localparam logic [POS_W-1:0] CODE_LAST_POS = 6'd38;

	// Code position of each data bit, from data bit 0 upward.
	localparam logic [POS_W-1:0] CODE_POS [DATA_W] = '{
		6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11, 6'd12,
		6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd30, 6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
	};

	// Request transaction.
	typedef struct packed {
		logic              req_type;
		logic [DATA_W-1:0] data_word;
		logic [7:0]        check_in;
	} cmd_t;

	// Result transaction.
	typedef struct packed {
		logic [DATA_W-1:0]  data_out;
		logic [CHECK_W-1:0] check_out;
		logic [1:0]         status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/secded_word_codec.sv -----
// ----------------------------------------------------------------------------
// SECDED word codec
// Hamming single-error-correct, double-error-detect codec for 32-bit words
// with a 7-bit check value.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction on cmd is taken at each rising edge where start is
//   high and busy is low. busy is always low, so a transaction may be
//   started in every cycle. An encode request returns the word unchanged
//   with its check value; a decode request returns the corrected word, the
//   check value of that word and a clean, corrected or uncorrectable status.
//   Each result appears on rsp for exactly one cycle with done high. The
//   request is registered, and the syndrome, correction and re-encode run
//   between that register and the result register that drives rsp.
//   Throughput is one transaction per cycle, set by that single
//   register-to-register pass.
//   Reset clears the valid flags of both stages, so no result is emitted
//   for requests in flight at reset. The receiver cannot stall: results are
//   never held back and must be taken in the cycle that done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module secded_word_codec (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire secded_pkg::cmd_t  cmd,
	output logic                   done,
	output secded_pkg::rsp_t       rsp
);

	secded_pkg::cmd_t                     cmd_s1;
	logic                                 valid_s1;
	logic [secded_pkg::DATA_W-1:0]        data_fix;
	logic [1:0]                           status_fix;
	logic [secded_pkg::CHECK_W-1:0]       check_fix;
	secded_pkg::rsp_t                     rsp_s2;
	logic                                 valid_s2;

	// The pipeline never holds off a request.
	assign busy = 1'b0;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// Syndrome, classification and correction.
	secded_corr u_corr (
		.cmd      (cmd_s1),
		.data_fix (data_fix),
		.status   (status_fix)
	);

	// Check value of the word that leaves the block.
	secded_enc u_enc (
		.word  (data_fix),
		.check (check_fix)
	);

	// Result register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2.data_out  <= data_fix;
			rsp_s2.check_out <= check_fix;
			rsp_s2.status    <= status_fix;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

`ifndef SYNTHESIS
	// A result only follows a request taken one stage earlier.
	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request in the first stage");

	// Every result carries one of the three defined status codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == secded_pkg::ST_CLEAN ||
			rsp.status == secded_pkg::ST_CORRECTED ||
			rsp.status == secded_pkg::ST_UNCORR))
		else $error("undefined status code on result");

	// The emitted codeword always has even overall parity.
	a_even_parity: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((^{rsp.data_out, rsp.check_out}) == 1'b0))
		else $error("result codeword has odd overall parity");

	// Encode passes the word through and reports clean.
	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1.req_type == secded_pkg::REQ_ENCODE) |=>
		(rsp.status == secded_pkg::ST_CLEAN && rsp.data_out == $past(cmd_s1.data_word)))
		else $error("encode transaction altered the word or status");

	// An uncorrectable word leaves the block unchanged.
	a_uncorr_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_fix == secded_pkg::ST_UNCORR) |=>
		(rsp.data_out == $past(cmd_s1.data_word)))
		else $error("uncorrectable transaction altered the word");
`endif

endmodule

`default_nettype wire

// ----- src/secded_enc.sv -----
// ----------------------------------------------------------------------------
// SECDED check generator
// Computes the six position check bits and the overall parity bit of a
// 32-bit data word as one flat XOR tree.
// ----------------------------------------------------------------------------
`default_nettype none

module secded_enc (
	input  wire logic [secded_pkg::DATA_W-1:0]  word,
	output logic      [secded_pkg::CHECK_W-1:0] check
);

	logic [secded_pkg::POS_W-1:0] pos_acc;

	// XOR of the code positions of all set data bits.
	always_comb begin
		pos_acc = '0;
		for (int i = 0; i < secded_pkg::DATA_W; i++) begin
			if (word[i]) begin
				pos_acc = pos_acc ^ secded_pkg::CODE_POS[i];
			end
		end
	end

	// Overall parity covers the data bits and the six check bits.
	assign check = {(^word) ^ (^pos_acc), pos_acc};

endmodule

`default_nettype wire

// ----- src/secded_corr.sv -----
// ----------------------------------------------------------------------------
// SECDED syndrome and correction
// Compares a data word with its stored check byte, classifies the error
// and flips the single data bit that the syndrome points at.
// ----------------------------------------------------------------------------
`default_nettype none

module secded_corr (
	input  wire secded_pkg::cmd_t                 cmd,
	output logic [secded_pkg::DATA_W-1:0]         data_fix,
	output logic [1:0]                            status
);

	logic [secded_pkg::CHECK_W-1:0] calc_check;
	logic [secded_pkg::POS_W-1:0]   syndrome;
	logic                           mismatch;
	logic [secded_pkg::DATA_W-1:0]  flip_mask;

	// Check value recomputed from the word as it arrived.
	secded_enc u_enc (
		.word  (cmd.data_word),
		.check (calc_check)
	);

	// The overall mismatch folds the data parity, the stored check bits and
	// the stored parity bit; the recomputed check bits fold to the data parity.
	assign syndrome = calc_check[secded_pkg::POS_W-1:0]
		^ cmd.check_in[secded_pkg::POS_W-1:0];
	assign mismatch = ^(calc_check ^ cmd.check_in[secded_pkg::CHECK_W-1:0]);

	// One comparator per data bit; zero, powers of two and positions past
	// the last data bit match none of them.
	always_comb begin
		for (int i = 0; i < secded_pkg::DATA_W; i++) begin
			flip_mask[i] = (syndrome == secded_pkg::CODE_POS[i]);
		end
	end

	// Classify the transaction and apply the correction.
	always_comb begin
		status   = secded_pkg::ST_CLEAN;
		data_fix = cmd.data_word;
		if (cmd.req_type == secded_pkg::REQ_DECODE) begin
			if (cmd.check_in[7]) begin
				status = secded_pkg::ST_UNCORR;
			end else if (!mismatch) begin
				status = (syndrome == '0) ? secded_pkg::ST_CLEAN : secded_pkg::ST_UNCORR;
			end else if (syndrome > secded_pkg::CODE_LAST_POS) begin
				status = secded_pkg::ST_UNCORR;
			end else begin
				status   = secded_pkg::ST_CORRECTED;
				data_fix = cmd.data_word ^ flip_mask;
			end
		end
	end

endmodule

`default_nettype wire
